[rtl/nfo_pkg.sv]
package nfo_pkg;

    localparam int MUL_W      = 64;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int PSI_W      = 24;
    localparam int DIV_N_W    = 46;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_RESISTANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INDUCTANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUX_LINKAGE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OBSERVER_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD    = 3'd4;

    typedef struct packed {
        logic signed [15:0] volt_alpha;
        logic signed [15:0] volt_beta;
        logic signed [15:0] amp_alpha;
        logic signed [15:0] amp_beta;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] unit_flux_alpha;
        logic signed [15:0] unit_flux_beta;
        logic [47:0]        flux_magnitude_sq;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [PSI_W-1:0]   divisor;
    } t_div_req;

endpackage

[rtl/nfo_in_if.sv]
interface nfo_in_if;
    import nfo_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[rtl/nfo_out_if.sv]
interface nfo_out_if;
    import nfo_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[rtl/nfo_mul.sv]
module nfo_mul (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  nfo_pkg::t_mul_req        i_req,
    output logic                     o_done,
    output logic [nfo_pkg::PROD_W-1:0] o_product
);
    import nfo_pkg::*;

    localparam int CNT_W = $clog2(MUL_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MUL_W-1:0] r_a;
    logic [MUL_W-1:0] r_hi;
    logic [MUL_W-1:0] r_lo;
    logic [MUL_W:0]   w_sum;

    // One multiplier bit per cycle: add the multiplicand into the upper half, shift right.
    always_comb begin
        w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a  <= i_req.a;
            r_hi <= '0;
            r_lo <= i_req.b;
        end else if (r_busy) begin
            r_hi <= w_sum[MUL_W:1];
            r_lo <= {w_sum[0], r_lo[MUL_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

[rtl/nfo_div.sv]
module nfo_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nfo_pkg::t_div_req           i_req,
    output logic                        o_done,
    output logic [nfo_pkg::DIV_N_W-1:0] o_quotient
);
    import nfo_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [PSI_W-1:0]   r_den;
    logic [PSI_W-1:0]   r_rem;
    logic [DIV_N_W-1:0] r_q;
    logic [PSI_W:0]     w_trial;
    logic               w_fit;

    // Restoring division: the dividend shifts out of r_q as quotient bits shift in.
    always_comb begin
        w_trial = {r_rem, r_q[DIV_N_W-1]};
        w_fit   = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_req.divisor;
            r_rem <= '0;
            r_q   <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= w_fit ? PSI_W'(w_trial - {1'b0, r_den}) : w_trial[PSI_W-1:0];
            r_q   <= {r_q[DIV_N_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

[rtl/nonlinear_flux_observer_core.sv]
// Each accepted input transaction runs through thirteen products on the bit-serial multiplier
// and up to two divisions; a division is skipped when its flux comes out zero.
// Only one transaction is worked on at a time: a new input can be taken the cycle after the
// result is registered. Reset (synchronous, active low) restores register defaults and clears state.
module nonlinear_flux_observer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [nfo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nfo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    nfo_in_if.sink                         i_in,
    nfo_out_if.source                      o_out
);
    import nfo_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_PSQ, S_RI, S_GE, S_TERM, S_V, S_VM, S_DX, S_INT, S_LI, S_ETA,
        S_SQS, S_SQA, S_SQB, S_DVS, S_DVW, S_DONE
    } t_state;

    t_state             r_state;
    logic [23:0]        r_res;
    logic [23:0]        r_ind;
    logic [23:0]        r_psi;
    logic [23:0]        r_gam;
    logic [31:0]        r_dt;
    logic signed [15:0] r_u [2];
    logic signed [15:0] r_i [2];
    logic signed [31:0] r_integ [2];
    logic signed [31:0] r_eta [2];
    logic signed [15:0] r_ratio [2];
    logic [47:0]        r_fsq;
    logic signed [48:0] r_err;
    logic signed [63:0] r_y;
    logic signed [63:0] r_acc;
    logic               r_vneg;
    logic               r_axis;
    logic [63:0]        r_sq;
    t_out_item          r_out;
    logic               r_out_valid;
    t_mul_req           r_mul;
    t_div_req           r_div;

    logic                w_mul_done;
    logic [PROD_W-1:0]   w_prod;
    logic                w_div_done;
    logic [DIV_N_W-1:0]  w_quot;

    logic [15:0]         w_i_mag;
    logic                w_i_neg;
    logic [31:0]         w_eta0_mag;
    logic [31:0]         w_eta1_mag;
    logic [31:0]         w_eta_mag;
    logic                w_eta_neg;
    logic [47:0]         w_err_mag;
    logic signed [63:0]  w_ri;
    logic signed [63:0]  w_u_sh;
    logic [62:0]         w_rnd48;
    logic [62:0]         w_rnd32;
    logic [62:0]         w_rnd12;
    logic [63:0]         w_v_mag;
    logic signed [63:0]  w_integ64;
    logic [63:0]         w_sum_sq;
    logic [DIV_N_W-1:0]  w_lim;
    logic [DIV_N_W-1:0]  w_qs;
    logic [15:0]         w_ratio;

    function automatic logic [62:0] rnd_sat(input logic [PROD_W-1:0] p, input int sh);
        logic [PROD_W:0] t;
        logic [PROD_W:0] r;
        t = {1'b0, p} + ((PROD_W+1)'(1) << (sh - 1));
        r = t >> sh;
        if (r > (PROD_W+1)'(64'h4000_0000_0000_0000)) begin
            return 63'h4000_0000_0000_0000;
        end
        return r[62:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    nfo_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (r_mul),
        .o_done    (w_mul_done),
        .o_product (w_prod)
    );

    nfo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (r_div),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        w_i_neg    = r_i[r_axis][15];
        w_i_mag    = w_i_neg ? (~r_i[r_axis] + 16'd1) : r_i[r_axis];
        w_eta0_mag = mag32(r_eta[0]);
        w_eta1_mag = mag32(r_eta[1]);
        w_eta_mag  = r_axis ? w_eta1_mag : w_eta0_mag;
        w_eta_neg  = r_axis ? r_eta[1][31] : r_eta[0][31];
        w_err_mag  = r_err[48] ? 48'(-r_err) : r_err[47:0];
        w_ri       = w_i_neg ? -$signed({24'd0, w_prod[39:0]}) : $signed({24'd0, w_prod[39:0]});
        w_u_sh     = {{32{r_u[r_axis][15]}}, r_u[r_axis], 16'd0};
        w_rnd48    = rnd_sat(w_prod, 48);
        w_rnd32    = rnd_sat(w_prod, 32);
        w_rnd12    = rnd_sat(w_prod, 12);
        w_v_mag    = r_acc[63] ? 64'(-r_acc) : r_acc;
        w_integ64  = {{32{r_integ[r_axis][31]}}, r_integ[r_axis]};
        w_sum_sq   = r_sq + w_prod[63:0];
        // A negative ratio may reach one step further than a positive one.
        w_lim      = w_eta_neg ? DIV_N_W'(32768) : DIV_N_W'(32767);
        w_qs       = (w_quot > w_lim) ? w_lim : w_quot;
        w_ratio    = w_eta_neg ? (16'd0 - w_qs[15:0]) : w_qs[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res       <= 24'd65536;
            r_ind       <= 24'd268435;
            r_psi       <= 24'd167772;
            r_gam       <= 24'd1000000;
            r_dt        <= 32'd214748;
            r_integ[0]  <= '0;
            r_integ[1]  <= '0;
            r_eta[0]    <= '0;
            r_eta[1]    <= '0;
            r_fsq       <= '0;
            r_out_valid <= 1'b0;
            r_mul.start <= 1'b0;
            r_div.start <= 1'b0;
            r_axis      <= 1'b0;
        end else begin
            r_mul.start <= 1'b0;
            r_div.start <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PHASE_RESISTANCE: r_res <= i_cfg_data[23:0];
                    CFG_PHASE_INDUCTANCE: r_ind <= i_cfg_data[23:0];
                    CFG_FLUX_LINKAGE:     r_psi <= i_cfg_data[23:0];
                    CFG_OBSERVER_GAIN:    r_gam <= i_cfg_data[23:0];
                    CFG_SAMPLE_PERIOD:    r_dt  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_u[0]      <= i_in.data.volt_alpha;
                        r_u[1]      <= i_in.data.volt_beta;
                        r_i[0]      <= i_in.data.amp_alpha;
                        r_i[1]      <= i_in.data.amp_beta;
                        r_mul.start <= 1'b1;
                        r_mul.a     <= {40'd0, r_psi};
                        r_mul.b     <= {40'd0, r_psi};
                        r_state     <= S_PSQ;
                    end
                end
                S_PSQ: begin
                    if (w_mul_done) begin
                        r_err       <= $signed({1'b0, w_prod[47:0]}) - $signed({1'b0, r_fsq});
                        r_axis      <= 1'b0;
                        r_mul.start <= 1'b1;
                        r_mul.a     <= {40'd0, r_res};
                        r_mul.b     <= {48'd0, r_i[0][15] ? (~r_i[0] + 16'd1) : r_i[0]};
                        r_state     <= S_RI;
                    end
                end
                S_RI: begin
                    if (w_mul_done) begin
                        r_y         <= w_u_sh - w_ri;
                        r_mul.start <= 1'b1;
                        r_mul.a     <= {32'd0, w_eta_mag};
                        r_mul.b     <= {40'd0, r_gam};
                        r_state     <= S_GE;
                    end
                end
                S_GE: begin
                    if (w_mul_done) begin
                        r_mul.start <= 1'b1;
                        r_mul.a     <= {8'd0, w_prod[55:0]};
                        r_mul.b     <= {16'd0, w_err_mag};
                        r_state     <= S_TERM;
                    end
                end
                S_TERM: begin
                    if (w_mul_done) begin
                        r_acc   <= (w_eta_neg ^ r_err[48]) ? -$signed({1'b0, w_rnd48})
                                                           : $signed({1'b0, w_rnd48});
                        r_state <= S_V;
                    end
                end
                S_V: begin
                    r_acc   <= r_y + r_acc;
                    r_state <= S_VM;
                end
                S_VM: begin
                    r_vneg      <= r_acc[63];
                    r_mul.start <= 1'b1;
                    r_mul.a     <= w_v_mag;
                    r_mul.b     <= {32'd0, r_dt};
                    r_state     <= S_DX;
                end
                S_DX: begin
                    if (w_mul_done) begin
                        r_acc   <= r_vneg ? -$signed({1'b0, w_rnd32}) : $signed({1'b0, w_rnd32});
                        r_state <= S_INT;
                    end
                end
                S_INT: begin
                    r_integ[r_axis] <= sat32(w_integ64 + r_acc);
                    r_mul.start     <= 1'b1;
                    r_mul.a         <= {40'd0, r_ind};
                    r_mul.b         <= {48'd0, w_i_mag};
                    r_state         <= S_LI;
                end
                S_LI: begin
                    if (w_mul_done) begin
                        r_acc   <= w_i_neg ? -$signed({1'b0, w_rnd12}) : $signed({1'b0, w_rnd12});
                        r_state <= S_ETA;
                    end
                end
                S_ETA: begin
                    r_eta[r_axis] <= sat32(w_integ64 - r_acc);
                    if (!r_axis) begin
                        r_axis      <= 1'b1;
                        r_mul.start <= 1'b1;
                        r_mul.a     <= {40'd0, r_res};
                        r_mul.b     <= {48'd0, r_i[1][15] ? (~r_i[1] + 16'd1) : r_i[1]};
                        r_state     <= S_RI;
                    end else begin
                        r_state <= S_SQS;
                    end
                end
                S_SQS: begin
                    r_mul.start <= 1'b1;
                    r_mul.a     <= {32'd0, w_eta0_mag};
                    r_mul.b     <= {32'd0, w_eta0_mag};
                    r_state     <= S_SQA;
                end
                S_SQA: begin
                    if (w_mul_done) begin
                        r_sq        <= w_prod[63:0];
                        r_mul.start <= 1'b1;
                        r_mul.a     <= {32'd0, w_eta1_mag};
                        r_mul.b     <= {32'd0, w_eta1_mag};
                        r_state     <= S_SQB;
                    end
                end
                S_SQB: begin
                    if (w_mul_done) begin
                        r_fsq   <= (w_sum_sq[63:48] != '0) ? 48'hffff_ffff_ffff : w_sum_sq[47:0];
                        r_axis  <= 1'b0;
                        r_state <= S_DVS;
                    end
                end
                S_DVS: begin
                    // A zero flux gives a zero ratio, also when the flux linkage is zero.
                    if (w_eta_mag == '0) begin
                        r_ratio[r_axis] <= '0;
                        if (!r_axis) begin
                            r_axis <= 1'b1;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_div.start    <= 1'b1;
                        r_div.dividend <= {w_eta_mag, 14'd0} + {22'd0, 1'b0, r_psi[23:1]};
                        r_div.divisor  <= r_psi;
                        r_state        <= S_DVW;
                    end
                end
                S_DVW: begin
                    if (w_div_done) begin
                        r_ratio[r_axis] <= w_ratio;
                        if (!r_axis) begin
                            r_axis  <= 1'b1;
                            r_state <= S_DVS;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out.unit_flux_alpha   <= r_ratio[0];
                        r_out.unit_flux_beta    <= r_ratio[1];
                        r_out.flux_magnitude_sq <= r_fsq;
                        r_out_valid             <= 1'b1;
                        r_state                 <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

[rtl/nfo_checker.sv]
module nfo_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input nfo_pkg::t_out_item i_out_data
);
    import nfo_pkg::*;

    // An accepted transaction keeps the input closed while it is worked on.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted transaction");

    // A result never appears in the cycle right after its input transaction.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result raised one cycle after input");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

endmodule

bind nonlinear_flux_observer_core nfo_checker u_nfo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

[tb/tb_nonlinear_flux_observer_core.sv]
module tb_nonlinear_flux_observer_core;
    import nfo_pkg::*;

    localparam longint WIDE_LIMIT   = 64'sh4000_0000_0000_0000;
    localparam logic [47:0] SQ_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 136;
    localparam int PRESSURE_CYCLES  = 4000;
    localparam int SETTLE_CYCLES    = 1000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    nfo_in_if  in_ch();
    nfo_out_if out_ch();

    nonlinear_flux_observer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    // Register shadow and observer state of the predictor.
    logic [23:0]        res_ohm;
    logic [23:0]        ind_henry;
    logic [23:0]        psi_wb;
    logic [23:0]        gain;
    logic [31:0]        period;
    int                 integ_a;
    int                 integ_b;
    int                 eta_a;
    int                 eta_b;
    logic [47:0]        flux_sq;

    t_out_item          expected_flux[$];
    int                 errors;
    int                 items_sent;
    int                 results_seen;
    int                 cfg_writes;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 hold_requests;
    int                 hold_served;
    int                 hold_left;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        t_in_item              item;
        bit                    known;
        t_out_item             want;
    } t_step;

    t_step directed[$];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #60_000_000;
        $display("nonlinear_flux_observer_core verification failed");
        $finish;
    end

    // Exact product of two signed values, shifted right with rounding to nearest
    // (ties away from zero) and saturated in magnitude.
    function automatic longint scaled_product(longint a, longint b, int sh, longint lim);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        logic         neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        p   = {64'd0, ma} * {64'd0, mb};
        p   = (p + (128'd1 << (sh - 1))) >> sh;
        if (p > 128'(lim))
            p = 128'(lim);
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic logic signed [15:0] unit_flux(int eta);
        logic [63:0] n;
        logic [63:0] lim;
        logic [63:0] q;
        n   = (eta < 0) ? 64'(-longint'(eta)) : 64'(longint'(eta));
        n   = n * 64'd16384;
        lim = (eta < 0) ? 64'd32768 : 64'd32767;
        if (psi_wb == 0)
            q = (n == 0) ? 64'd0 : lim;
        else
            q = (n + 64'(psi_wb / 2)) / 64'(psi_wb);
        if (q > lim)
            q = lim;
        return (eta < 0) ? 16'(-longint'(q)) : 16'(q);
    endfunction

    function automatic void observe_axis(inout int integ, inout int eta, input longint u,
                                         input longint cur, input longint err);
        longint y;
        longint ge;
        longint term;
        longint dx;
        longint li;
        y     = u * 65536 - longint'(res_ohm) * cur;
        ge    = longint'(eta) * longint'(gain);
        term  = scaled_product(ge, err, 48, WIDE_LIMIT);
        dx    = scaled_product(y + term, longint'(period), 32, WIDE_LIMIT);
        integ = clamp32(longint'(integ) + dx);
        li    = scaled_product(longint'(ind_henry), cur, 12, WIDE_LIMIT);
        eta   = clamp32(longint'(integ) - li);
    endfunction

    function automatic t_out_item observer_step(t_in_item it);
        longint      err;
        logic [63:0] sa;
        logic [63:0] sb;
        logic [64:0] sq;
        t_out_item   r;
        err = longint'(psi_wb) * longint'(psi_wb) - longint'(flux_sq);
        observe_axis(integ_a, eta_a, longint'(it.volt_alpha), longint'(it.amp_alpha), err);
        observe_axis(integ_b, eta_b, longint'(it.volt_beta), longint'(it.amp_beta), err);
        sa = (eta_a < 0) ? 64'(-longint'(eta_a)) : 64'(longint'(eta_a));
        sb = (eta_b < 0) ? 64'(-longint'(eta_b)) : 64'(longint'(eta_b));
        sq = 65'(sa * sa) + 65'(sb * sb);
        flux_sq = (sq > 65'(SQ_MAX)) ? SQ_MAX : sq[47:0];
        r.unit_flux_alpha   = unit_flux(eta_a);
        r.unit_flux_beta    = unit_flux(eta_b);
        r.flux_magnitude_sq = flux_sq;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
        errors++;
    endtask

    // Receiver: random backpressure, a long hold on request, and result checking.
    always @(posedge i_clk) begin
        t_out_item want;
        if (out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (expected_flux.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
            end else begin
                want = expected_flux.pop_front();
                if (out_ch.data.unit_flux_alpha !== want.unit_flux_alpha)
                    report_mismatch("unit_flux_alpha", out_ch.data.unit_flux_alpha,
                                    want.unit_flux_alpha);
                if (out_ch.data.unit_flux_beta !== want.unit_flux_beta)
                    report_mismatch("unit_flux_beta", out_ch.data.unit_flux_beta,
                                    want.unit_flux_beta);
                if (out_ch.data.flux_magnitude_sq !== want.flux_magnitude_sq)
                    report_mismatch("flux_magnitude_sq", out_ch.data.flux_magnitude_sq,
                                    want.flux_magnitude_sq);
            end
        end
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            out_ch.ready <= 1'b0;
            hold_left    <= PRESSURE_CYCLES;
            hold_served  <= hold_requests;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
        case (idx)
            CFG_PHASE_RESISTANCE: res_ohm   = val[23:0];
            CFG_PHASE_INDUCTANCE: ind_henry = val[23:0];
            CFG_FLUX_LINKAGE:     psi_wb    = val[23:0];
            CFG_OBSERVER_GAIN:    gain      = val[23:0];
            CFG_SAMPLE_PERIOD:    period    = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (expected_flux.size() != 0)
            @(posedge i_clk);
    endtask

    // Offers one transaction and returns once it is accepted. A typed expectation,
    // when given, replaces the predicted one, though the predictor still advances.
    task automatic send_item(t_in_item it, bit known, t_out_item want);
        t_out_item pred;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        pred = observer_step(it);
        expected_flux.push_back(known ? want : pred);
        items_sent++;
    endtask

    function automatic void add_item(int va, int vb, int ia, int ib);
        t_step s;
        s.is_cfg          = 1'b0;
        s.item.volt_alpha = 16'(va);
        s.item.volt_beta  = 16'(vb);
        s.item.amp_alpha  = 16'(ia);
        s.item.amp_beta   = 16'(ib);
        s.known           = 1'b0;
        s.want            = '0;
        directed.push_back(s);
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_step s;
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.val    = val;
        s.item   = '0;
        s.known  = 1'b0;
        s.want   = '0;
        directed.push_back(s);
    endfunction

    function automatic logic [15:0] field_value(bit realistic, int amp);
        if (realistic)
            return 16'($signed($urandom_range(2 * amp)) - amp);
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_reg(int kind, logic [31:0] top, logic [31:0] dflt);
        case (kind)
            0:       return 32'd0;
            1:       return top;
            2:       return dflt + $urandom_range(dflt / 4);
            default: return $urandom & top;
        endcase
    endfunction

    initial begin
        t_in_item  it;
        t_out_item none;
        bit        realistic;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        out_ch.ready  = 1'b0;
        errors        = 0;
        items_sent    = 0;
        results_seen  = 0;
        cfg_writes    = 0;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;
        send_idle_pct = 25;
        recv_idle_pct = 50;
        none          = '0;
        res_ohm       = 24'd65536;
        ind_henry     = 24'd268435;
        psi_wb        = 24'd167772;
        gain          = 24'd1000000;
        period        = 32'd214748;
        integ_a       = 0;
        integ_b       = 0;
        eta_a         = 0;
        eta_b         = 0;
        flux_sq       = '0;

        // Zero input from reset leaves every state at zero.
        add_item(0, 0, 0, 0);
        directed[0].known = 1'b1;
        add_item(32767, 32767, 32767, 32767);
        add_item(-32768, -32768, -32768, -32768);
        add_item(32767, -32768, -32768, 32767);
        add_item(0, 0, 1, -1);
        add_item(1536, -1536, 256, -256);
        add_cfg(CFG_OBSERVER_GAIN, 32'hFF_FFFF);
        add_item(3000, -3000, 100, 50);
        add_item(-3000, 3000, -100, -50);
        add_cfg(CFG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
        add_item(32767, -32768, 0, 0);
        add_item(32767, -32768, 0, 0);
        add_cfg(CFG_FLUX_LINKAGE, 32'd0);
        add_item(-32768, 32767, 5, -5);
        add_cfg(CFG_SAMPLE_PERIOD, 32'd0);
        add_item(1000, 1000, 2000, -2000);
        add_cfg(CFG_UNUSED_LO, 32'hFFFF_FFFF);
        add_cfg(CFG_UNUSED_HI, 32'h1234_5678);
        add_item(-1000, 500, -32768, 32767);
        add_cfg(CFG_FLUX_LINKAGE, 32'd1);
        add_cfg(CFG_PHASE_RESISTANCE, 32'hFF_FFFF);
        add_cfg(CFG_PHASE_INDUCTANCE, 32'hFF_FFFF);
        add_cfg(CFG_SAMPLE_PERIOD, 32'd1);
        add_item(0, 0, 32767, -32768);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            if (directed[k].is_cfg) begin
                in_ch.valid <= 1'b0;
                wait_idle();
                write_reg(directed[k].idx, directed[k].val);
            end else begin
                send_item(directed[k].item, directed[k].known, directed[k].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            in_ch.valid <= 1'b0;
            wait_idle();
            send_idle_pct = (ph < 3) ? 25 : (ph < 6) ? 50 : 0;
            recv_idle_pct = (ph < 3) ? 50 : (ph < 6) ? 25 : 0;
            if (ph == 0) begin
                // Nominal motor parameters, equal to the reset defaults.
                write_reg(CFG_PHASE_RESISTANCE, 32'd65536);
                write_reg(CFG_PHASE_INDUCTANCE, 32'd268435);
                write_reg(CFG_FLUX_LINKAGE, 32'd167772);
                write_reg(CFG_OBSERVER_GAIN, 32'd1000000);
                write_reg(CFG_SAMPLE_PERIOD, 32'd214748);
            end else begin
                write_reg(CFG_PHASE_RESISTANCE,
                          pick_reg($urandom_range(3), 32'hFF_FFFF, 32'd65536));
                write_reg(CFG_PHASE_INDUCTANCE,
                          pick_reg($urandom_range(3), 32'hFF_FFFF, 32'd268435));
                write_reg(CFG_FLUX_LINKAGE,
                          pick_reg($urandom_range(3), 32'hFF_FFFF, 32'd167772));
                write_reg(CFG_OBSERVER_GAIN,
                          pick_reg($urandom_range(3), 32'hFF_FFFF, 32'd1000000));
                write_reg(CFG_SAMPLE_PERIOD,
                          pick_reg($urandom_range(3), 32'hFFFF_FFFF, 32'd214748));
            end
            // Receiver holds off while the sender keeps offering transactions.
            if (ph == 1)
                hold_requests++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                realistic     = ($urandom_range(99) < 75);
                it.volt_alpha = field_value(realistic, 6144);
                it.volt_beta  = field_value(realistic, 6144);
                it.amp_alpha  = field_value(realistic, 2560);
                it.amp_beta   = field_value(realistic, 2560);
                send_item(it, 1'b0, none);
            end
        end
        in_ch.valid <= 1'b0;

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d input transactions and %0d results over %0d register writes,",
                 items_sent, results_seen, cfg_writes);
        $display("with register extremes, zero flux linkage and period, and a long output stall.");
        if (errors == 0 && expected_flux.size() == 0) begin
            $display("nonlinear_flux_observer_core verification clean");
        end else begin
            $display("nonlinear_flux_observer_core verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/nfo_pkg.sv
rtl/nfo_in_if.sv
rtl/nfo_out_if.sv
rtl/nfo_mul.sv
rtl/nfo_div.sv
rtl/nonlinear_flux_observer_core.sv
rtl/nfo_checker.sv
tb/tb_nonlinear_flux_observer_core.sv
